[sv/pos_pkg.sv]
// ----------------------------------------------------------------------------
// pos_pkg
// Shared types and constants for the playlist order sequencer.
// ----------------------------------------------------------------------------
package pos_pkg;
  localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

  typedef enum logic [2:0] {
    F_ADD = 3'd0, F_REMOVE = 3'd1, F_SETCUR = 3'd2, F_CLEAR = 3'd3,
    F_SHUF = 3'd4, F_NEXT = 3'd5, F_PREV = 3'd6, F_ADV = 3'd7
  } func_t;

  localparam logic REG_LOOP = 1'b0;
  localparam logic REG_SEED = 1'b1;

  // request / response between sequencer and modulo unit
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [6:0]  den;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [6:0] rem;
  } mod_rsp_t;
endpackage

[sv/pos_mix.sv]
// ----------------------------------------------------------------------------
// pos_mix
// Multi-cycle splitmix64 output mix; 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module pos_mix import pos_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] state_in,
  output logic        done,
  output logic [63:0] result
);
  // step: 0 idle, 1..3 mult1 partials, 4..6 mult2 partials, 7 finish
  logic [2:0]  step_r, step_nxt;
  logic [63:0] z_r, z_nxt, acc_r, acc_nxt;
  logic [63:0] k;
  logic [31:0] a, b;
  logic [63:0] prod;
  logic [2:0]  ph;

  // one 32x32 multiplier shared across partial products
  always_comb begin
    ph = (step_r >= 3'd4) ? step_r - 3'd3 : step_r;
    k  = (step_r >= 3'd4) ? MIX2 : MIX1;
    a = z_r[31:0]; b = k[31:0];
    case (ph)
      3'd1: begin a = z_r[31:0];  b = k[31:0];  end
      3'd2: begin a = z_r[63:32]; b = k[31:0];  end
      3'd3: begin a = z_r[31:0];  b = k[63:32]; end
      default: ;
    endcase
    prod = a * b;
  end

  always_comb begin
    step_nxt = step_r; z_nxt = z_r; acc_nxt = acc_r; done = 1'b0;
    case (step_r)
      3'd0: if (start) begin
        z_nxt = state_in ^ (state_in >> 30); acc_nxt = '0; step_nxt = 3'd1;
      end
      3'd1, 3'd4: begin acc_nxt = prod; step_nxt = step_r + 3'd1; end
      3'd2, 3'd5: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0}; step_nxt = step_r + 3'd1;
      end
      3'd3: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
        z_nxt = acc_nxt ^ (acc_nxt >> 27); step_nxt = 3'd4;
      end
      3'd6: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0}; step_nxt = 3'd7;
      end
      3'd7: begin done = 1'b1; step_nxt = 3'd0; end
      default: step_nxt = 3'd0;
    endcase
  end

  assign result = acc_r ^ (acc_r >> 31);

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= 3'd0;
    else step_r <= step_nxt;
    z_r <= z_nxt;
    acc_r <= acc_nxt;
  end
endmodule

[sv/pos_mod.sv]
// ----------------------------------------------------------------------------
// pos_mod
// Restoring remainder of a 64-bit value by a 7-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module pos_mod import pos_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] num_r;
  logic [6:0]  den_r, rem_r;
  logic [7:0]  trial;

  assign trial = {rem_r, num_r[63]};
  assign rsp = {done_r, rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1; cnt_r <= 6'd0;
        num_r <= req.num; den_r <= req.den; rem_r <= '0;
      end else if (busy_r) begin
        // shift one bit in and subtract when it fits
        if (trial >= {1'b0, den_r}) rem_r <= 7'(trial - {1'b0, den_r});
        else rem_r <= trial[6:0];
        num_r <= {num_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin busy_r <= 1'b0; done_r <= 1'b1; end
      end
    end
  end
endmodule

[sv/playlist_order_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// playlist_order_sequencer_unit
// Playlist order sequencer: count, current entry, played flags, shuffle.
// ----------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_func, in_index, in_shuffle_on
// out     | output    | out_valid, out_ready, out_pick_index, out_pick_valid, out_ok
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
// Simple commands: after the input transfer the unit passes through S_EXEC and
// offers the result in S_OUT. A shuffled draw passes through S_EXEC, S_DRAW,
// S_MIX, the bit-serial remainder in S_MOD, S_FIN and S_OUT.
// A shuffled advance adds a pass in S_COUNT to count unplayed entries and,
// when one is drawn from them, a scan in S_LOCATE to locate it.
// Synchronous active-low reset; no clearing pass. in_ready and cfg_ready are
// low while a command runs and while a result waits on out_ready.
// ----------------------------------------------------------------------------
module playlist_order_sequencer_unit import pos_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [5:0]  in_index,
  input  logic        in_shuffle_on,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_pick_index,
  output logic        out_pick_valid,
  output logic        out_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DRAW, S_MIX, S_MOD, S_COUNT, S_LOCATE, S_FIN, S_OUT
  } state_t;
  // what a draw result is used for
  typedef enum logic [1:0] { D_OTHER, D_ROUND, D_NEW } dmode_t;

  state_t      state_r, state_nxt;
  dmode_t      dmode_r, dmode_nxt;
  logic [1:0]  loop_r, loop_nxt;
  logic [63:0] gen_r, gen_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  cur_r, cur_nxt;
  logic        curv_r, curv_nxt, shuf_r, shuf_nxt;
  logic [63:0] played_r, played_nxt;
  logic [2:0]  func_r, func_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        on_r, on_nxt;
  logic [6:0]  scan_r, scan_nxt, n_r, n_nxt, seen_r, seen_nxt, rem_r, rem_nxt;
  logic [5:0]  pick_r, pick_nxt;
  logic        pv_r, pv_nxt, ok_r, ok_nxt;
  logic        mix_start, mix_done;
  logic [63:0] mix_res;
  mod_req_t    mreq;
  mod_rsp_t    mrsp;
  logic [63:0] gen_inc, low_mask, rm_flags;
  logic [5:0]  sidx;

  assign gen_inc = gen_r + GOLDEN;
  assign sidx = scan_r[5:0];

  // the mix works on the advanced generator state
  pos_mix u_mix (.clk, .rst_n, .start(mix_start), .state_in(gen_inc),
                 .done(mix_done), .result(mix_res));
  pos_mod u_mod (.clk, .rst_n, .req(mreq), .rsp(mrsp));

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_pick_index = pick_r;
  assign out_pick_valid = pv_r;
  assign out_ok = ok_r;
  assign mix_start = (state_r == S_DRAW);

  always_comb begin
    mreq.start = (state_r == S_MIX) && mix_done;
    mreq.num = mix_res;
    case (dmode_r)
      D_OTHER: mreq.den = cnt_r;
      D_ROUND: mreq.den = n_r;
      default: mreq.den = cnt_r - 7'd1;
    endcase
  end

  // remove: close the gap in the played flags
  always_comb begin
    low_mask = (64'd1 << idx_r) - 64'd1;
    rm_flags = (played_r & low_mask) | (((played_r >> idx_r) >> 1) << idx_r);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r; dmode_nxt = dmode_r; loop_nxt = loop_r; gen_nxt = gen_r;
    cnt_nxt = cnt_r; cur_nxt = cur_r; curv_nxt = curv_r; shuf_nxt = shuf_r;
    played_nxt = played_r; func_nxt = func_r; idx_nxt = idx_r; on_nxt = on_r;
    scan_nxt = scan_r; n_nxt = n_r; seen_nxt = seen_r; rem_nxt = rem_r;
    pick_nxt = pick_r; pv_nxt = pv_r; ok_nxt = ok_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LOOP) loop_nxt = cfg_data[1:0];
      else gen_nxt = cfg_data;
    end
    case (state_r)
      S_IDLE: if (in_valid) begin
        func_nxt = in_func; idx_nxt = in_index; on_nxt = in_shuffle_on;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pick_nxt = '0; pv_nxt = 1'b0; ok_nxt = 1'b1; state_nxt = S_OUT;
        case (func_t'(func_r))
          F_ADD: if (cnt_r >= 7'(MAX_ENTRIES)) ok_nxt = 1'b0;
          else begin
            cnt_nxt = cnt_r + 7'd1;
            played_nxt[cnt_r[5:0]] = 1'b0;
            if (!curv_r) begin cur_nxt = cnt_r[5:0]; curv_nxt = 1'b1; end
          end
          F_REMOVE: if ({1'b0, idx_r} >= cnt_r) ok_nxt = 1'b0;
          else begin
            played_nxt = rm_flags;
            cnt_nxt = cnt_r - 7'd1;
            if (cnt_r == 7'd1) begin cur_nxt = '0; curv_nxt = 1'b0; end
            else if (curv_r) begin
              if (idx_r < cur_r) cur_nxt = cur_r - 6'd1;
              else if ({1'b0, cur_r} >= cnt_r - 7'd1) cur_nxt = 6'(cnt_r - 7'd2);
            end
          end
          F_SETCUR: if ({1'b0, idx_r} >= cnt_r) ok_nxt = 1'b0;
          else begin cur_nxt = idx_r; curv_nxt = 1'b1; end
          F_CLEAR: begin
            cnt_nxt = '0; played_nxt = '0; cur_nxt = '0; curv_nxt = 1'b0;
          end
          F_SHUF: if (on_r != shuf_r) begin shuf_nxt = on_r; played_nxt = '0; end
          default: if (cnt_r != 7'd0 && curv_r) begin
            pv_nxt = 1'b1;
            if (func_r == F_ADV && loop_r == 2'd1) pick_nxt = cur_r;
            else if (func_r == F_ADV && shuf_r) begin
              played_nxt[cur_r] = 1'b1;
              scan_nxt = '0; n_nxt = '0; state_nxt = S_COUNT;
            end else if (shuf_r && cnt_r > 7'd1) begin
              dmode_nxt = D_OTHER; state_nxt = S_DRAW;
            end else if (func_r == F_PREV) begin
              if (cur_r != 6'd0) pick_nxt = cur_r - 6'd1;
              else if (loop_r == 2'd0) pv_nxt = 1'b0;
              else pick_nxt = 6'(cnt_r - 7'd1);
            end else begin
              if ({1'b0, cur_r} + 7'd1 < cnt_r) pick_nxt = cur_r + 6'd1;
              else if (loop_r == 2'd0) pv_nxt = 1'b0;
            end
          end
        endcase
      end
      // count unplayed entries, one per cycle
      S_COUNT: begin
        if (scan_r == cnt_r) begin
          if (n_r != 7'd0) begin dmode_nxt = D_ROUND; state_nxt = S_DRAW; end
          else if (loop_r == 2'd0) begin pv_nxt = 1'b0; state_nxt = S_OUT; end
          else begin
            played_nxt = '0;
            if (cnt_r <= 7'd1) begin pick_nxt = cur_r; state_nxt = S_OUT; end
            else begin dmode_nxt = D_NEW; state_nxt = S_DRAW; end
          end
        end else begin
          if (!played_r[sidx]) n_nxt = n_r + 7'd1;
          scan_nxt = scan_r + 7'd1;
        end
      end
      S_DRAW: begin gen_nxt = gen_inc; state_nxt = S_MIX; end
      S_MIX: if (mix_done) state_nxt = S_MOD;
      S_MOD: if (mrsp.done) begin
        rem_nxt = mrsp.rem; state_nxt = S_FIN;
      end
      S_FIN: begin
        case (dmode_r)
          D_OTHER: begin
            state_nxt = S_OUT;
            if (rem_r[5:0] == cur_r)
              pick_nxt = (rem_r + 7'd1 == cnt_r) ? 6'd0 : rem_r[5:0] + 6'd1;
            else pick_nxt = rem_r[5:0];
          end
          D_NEW: begin
            state_nxt = S_OUT;
            pick_nxt = (rem_r[5:0] < cur_r) ? rem_r[5:0] : rem_r[5:0] + 6'd1;
          end
          default: begin
            scan_nxt = '0; seen_nxt = '0; state_nxt = S_LOCATE;
          end
        endcase
      end
      // locate the rem-th unplayed entry
      S_LOCATE: begin
        if (scan_r == cnt_r) begin pick_nxt = cur_r; state_nxt = S_OUT; end
        else if (!played_r[sidx] && seen_r == rem_r) begin
          pick_nxt = sidx; state_nxt = S_OUT;
        end else begin
          if (!played_r[sidx]) seen_nxt = seen_r + 7'd1;
          scan_nxt = scan_r + 7'd1;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; dmode_r <= D_OTHER; loop_r <= 2'd0; gen_r <= '0;
      cnt_r <= '0; cur_r <= '0; curv_r <= 1'b0; shuf_r <= 1'b0; played_r <= '0;
      func_r <= '0; idx_r <= '0; on_r <= 1'b0; scan_r <= '0; n_r <= '0;
      seen_r <= '0; rem_r <= '0; pick_r <= '0; pv_r <= 1'b0; ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt; dmode_r <= dmode_nxt; loop_r <= loop_nxt;
      gen_r <= gen_nxt; cnt_r <= cnt_nxt; cur_r <= cur_nxt; curv_r <= curv_nxt;
      shuf_r <= shuf_nxt; played_r <= played_nxt; func_r <= func_nxt;
      idx_r <= idx_nxt; on_r <= on_nxt; scan_r <= scan_nxt; n_r <= n_nxt;
      seen_r <= seen_nxt; rem_r <= rem_nxt; pick_r <= pick_nxt; pv_r <= pv_nxt;
      ok_r <= ok_nxt;
    end
  end

  // entry count stays within the configured depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 7'(MAX_ENTRIES)) else $error("entry count overflow");
  // a valid current entry always lies within the list
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (curv_r |-> ({1'b0, cur_r} < cnt_r))) else $error("current out of range");
  // a pick never names an entry past the list
  a_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pick_valid) |-> ({1'b0, out_pick_index} < cnt_r))
    else $error("pick out of range");
endmodule
